/* design/gphm_pkg.sv */
// Package for the group-probed hash map: widths, metadata codes, status codes
// and the request record passed from the front part to the back part.
// No dependencies.
`default_nettype none
package gphm_pkg;

    // Table geometry
    localparam int GROUP_COUNT_DEF = 64;
    localparam int LANES           = 16;
    localparam int LW              = $clog2(LANES);

    // Metadata byte codes
    localparam logic [7:0] META_EMPTY = 8'h01;
    localparam logic [7:0] META_DEAD  = 8'h02;
    localparam logic [7:0] TAG_MASK   = 8'hFC;

    // Result status codes
    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_ABSENT   = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Operation codes
    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_SET    = 1'b1;

    // Classified request held in the queue between front and back
    typedef struct packed {
        logic        mode;
        logic [63:0] key_hash;
        logic [31:0] node_index;
        logic [7:0]  tag;
    } t_req;

endpackage
`default_nettype wire

/* design/gphm_if.sv */
// Valid/ready channel interfaces for the request and response sides.
// Depends on nothing.
`default_nettype none
interface gphm_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [63:0] key_hash;
    logic [31:0] node_index;

    modport source (output valid, mode, key_hash, node_index, input ready);
    modport sink   (input valid, mode, key_hash, node_index, output ready);
endinterface

interface gphm_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] found_index;

    modport source (output valid, status, found_index, input ready);
    modport sink   (input valid, status, found_index, output ready);
endinterface
`default_nettype wire

/* design/gphm_front.sv */
// Front part: accepts requests, derives the tag and holds them in a two-entry
// queue for the back part. Depends on gphm_pkg and gphm_req_if.
`default_nettype none
module gphm_front
    import gphm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gphm_req_if.sink  i_req,
    input  wire logic i_hold,
    output t_req      o_entry,
    output logic      o_valid,
    input  wire logic i_pop
);
    localparam int QDEPTH = 2;

    t_req       r_q [QDEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    // Take requests only when there is room and the table is not being cleared
    assign i_req.ready = (r_cnt != 2'(QDEPTH)) && !i_hold;
    assign w_push      = i_req.valid && i_req.ready;
    assign w_pop       = i_pop && (r_cnt != 2'd0);
    assign o_valid     = (r_cnt != 2'd0);
    assign o_entry     = r_q[r_rd_ptr];

    // Classify and store
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr].mode       <= i_req.mode;
            r_q[r_wr_ptr].key_hash   <= i_req.key_hash;
            r_q[r_wr_ptr].node_index <= i_req.node_index;
            r_q[r_wr_ptr].tag        <= i_req.key_hash[7:0] & TAG_MASK;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule
`default_nettype wire

/* design/gphm_back.sv */
// Back part: clears the table after reset, probes groups one at a time,
// inserts on a miss in set mode and holds the response. Depends on gphm_pkg, gphm_rsp_if.
`default_nettype none
module gphm_back
    import gphm_pkg::*;
#(
    parameter int GROUP_COUNT = GROUP_COUNT_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_req  i_entry,
    input  wire logic  i_valid,
    output logic       o_pop,
    output logic       o_clearing,
    gphm_rsp_if.source o_rsp
);
    localparam int AW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int CW = $clog2(GROUP_COUNT + 1);
    localparam logic [AW-1:0] GMASK = AW'(GROUP_COUNT - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // Group-wide memories
    logic [LANES-1:0][7:0]  r_meta_mem [GROUP_COUNT];
    logic [LANES-1:0][63:0] r_hash_mem [GROUP_COUNT];
    logic [LANES-1:0][31:0] r_val_mem  [GROUP_COUNT];
    logic [LANES-1:0][7:0]  r_rd_meta;
    logic [LANES-1:0][63:0] r_rd_hash;
    logic [LANES-1:0][31:0] r_rd_val;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    t_req          r_req, n_req;
    logic [AW-1:0] r_grp, n_grp;
    logic [AW-1:0] r_sq, n_sq;
    logic [AW-1:0] r_odd, n_odd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_cand_v, n_cand_v;
    logic [AW-1:0] r_cand_grp, n_cand_grp;
    logic [LW-1:0] r_cand_lane, n_cand_lane;
    logic [1:0]    r_res_st, n_res_st;
    logic [31:0]   r_res_idx, n_res_idx;
    logic          r_out_v, n_out_v;
    logic [1:0]    r_out_st, n_out_st;
    logic [31:0]   r_out_idx, n_out_idx;

    logic [LANES-1:0] w_hit, w_emp, w_dead;
    logic [LW-1:0]    w_hit_lane, w_emp_lane, w_dead_lane;
    logic             w_any_hit, w_any_emp, w_any_dead;
    logic             w_rd_en, w_wr_en;

    // Lane compares on the group just read
    always_comb begin
        w_hit_lane  = '0;
        w_emp_lane  = '0;
        w_dead_lane = '0;
        for (int l = 0; l < LANES; l++) begin
            w_hit[l]  = (r_rd_meta[l] == r_req.tag) && (r_rd_hash[l] == r_req.key_hash);
            w_emp[l]  = (r_rd_meta[l] == META_EMPTY);
            w_dead[l] = (r_rd_meta[l] == META_DEAD);
        end
        for (int l = LANES - 1; l >= 0; l--) begin
            if (w_hit[l])  w_hit_lane  = LW'(l);
            if (w_emp[l])  w_emp_lane  = LW'(l);
            if (w_dead[l]) w_dead_lane = LW'(l);
        end
        w_any_hit  = |w_hit;
        w_any_emp  = |w_emp;
        w_any_dead = |w_dead;
    end

    assign w_rd_en    = (r_state == S_READ);
    assign w_wr_en    = (r_state == S_WRITE);
    assign o_clearing = (r_state == S_CLEAR);

    // Memory write and registered group read
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_meta_mem[r_clr] <= {LANES{META_EMPTY}};
        end else if (w_wr_en) begin
            r_meta_mem[r_cand_grp][r_cand_lane] <= r_req.tag;
            r_hash_mem[r_cand_grp][r_cand_lane] <= r_req.key_hash;
            r_val_mem[r_cand_grp][r_cand_lane]  <= r_req.node_index;
        end
        if (w_rd_en) begin
            r_rd_meta <= r_meta_mem[r_grp];
            r_rd_hash <= r_hash_mem[r_grp];
            r_rd_val  <= r_val_mem[r_grp];
        end
    end

    // Probe sequencer
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_req       = r_req;
        n_grp       = r_grp;
        n_sq        = r_sq;
        n_odd       = r_odd;
        n_cnt       = r_cnt;
        n_cand_v    = r_cand_v;
        n_cand_grp  = r_cand_grp;
        n_cand_lane = r_cand_lane;
        n_res_st    = r_res_st;
        n_res_idx   = r_res_idx;
        n_out_v     = r_out_v;
        n_out_st    = r_out_st;
        n_out_idx   = r_out_idx;
        o_pop       = 1'b0;

        // Drop the response once taken
        if (r_out_v && o_rsp.ready) n_out_v = 1'b0;

        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(GROUP_COUNT - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_pop    = 1'b1;
                    n_req    = i_entry;
                    n_grp    = i_entry.key_hash[AW-1:0] & GMASK;
                    n_sq     = AW'(1);
                    n_odd    = AW'(3);
                    n_cnt    = '0;
                    n_cand_v = 1'b0;
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (w_any_hit) begin
                    n_res_st  = ST_FOUND;
                    n_res_idx = r_rd_val[w_hit_lane];
                    n_state   = S_DONE;
                end else begin
                    // Note the first group with room for an insert
                    if (!r_cand_v && (w_any_emp || w_any_dead)) begin
                        n_cand_v    = 1'b1;
                        n_cand_grp  = r_grp;
                        n_cand_lane = w_any_emp ? w_emp_lane : w_dead_lane;
                    end
                    n_res_idx = '0;
                    n_cnt     = r_cnt + CW'(1);
                    if (w_any_emp || (r_cnt + CW'(1) == CW'(GROUP_COUNT))) begin
                        if (r_req.mode == MODE_SET && (r_cand_v || w_any_emp || w_any_dead)) begin
                            n_state = S_WRITE;
                        end else begin
                            n_res_st = (r_req.mode == MODE_SET) ? ST_FULL
                                     : (w_any_emp ? ST_ABSENT : ST_FULL);
                            n_state  = S_DONE;
                        end
                    end else begin
                        n_grp   = (r_grp + r_sq) & GMASK;
                        n_sq    = r_sq + r_odd;
                        n_odd   = r_odd + AW'(2);
                        n_state = S_READ;
                    end
                end
            end
            S_WRITE: begin
                n_res_st  = ST_INSERTED;
                n_res_idx = '0;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_v || o_rsp.ready) begin
                    n_out_v   = 1'b1;
                    n_out_st  = r_res_st;
                    n_out_idx = r_res_idx;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_out_v <= n_out_v;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_grp       <= n_grp;
        r_sq        <= n_sq;
        r_odd       <= n_odd;
        r_cnt       <= n_cnt;
        r_cand_v    <= n_cand_v;
        r_cand_grp  <= n_cand_grp;
        r_cand_lane <= n_cand_lane;
        r_res_st    <= n_res_st;
        r_res_idx   <= n_res_idx;
        r_out_st    <= n_out_st;
        r_out_idx   <= n_out_idx;
    end

    assign o_rsp.valid       = r_out_v;
    assign o_rsp.status      = r_out_st;
    assign o_rsp.found_index = r_out_idx;
endmodule
`default_nettype wire

/* design/group_probed_hash_map.sv */
// Group-probed hash map from 64-bit key hashes to 32-bit node indices.
// Channels: i_req (mode, key_hash, node_index) in, o_rsp (status,
// found_index) out, both valid/ready; an item moves when valid and ready
// are high at a rising edge. Exactly one response per request, in order.
// Each probe reads one 16-lane group from the group memories in S_READ and
// compares its lanes in S_EVAL. A request is taken in S_IDLE, passes
// S_READ and S_EVAL for each group visited, then S_WRITE for an insert,
// and S_DONE loads the response register.
// Up to two requests wait in the front queue while the back part probes.
// After reset the metadata memory is cleared one group per cycle, during
// which i_req.ready stays low.
// When the receiver stalls, the response register holds; the back part
// finishes its current request and waits, and the queue keeps accepting
// until full.
// Depends on gphm_pkg, gphm_if, gphm_front and gphm_back.
`default_nettype none
module group_probed_hash_map
    import gphm_pkg::*;
#(
    parameter int GROUP_COUNT = GROUP_COUNT_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gphm_req_if.sink   i_req,
    gphm_rsp_if.source o_rsp
);
    t_req w_entry;
    logic w_valid;
    logic w_pop;
    logic w_clearing;

    // Accept and queue
    gphm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_hold  (w_clearing),
        .o_entry (w_entry),
        .o_valid (w_valid),
        .i_pop   (w_pop)
    );

    // Probe, insert and respond
    gphm_back #(
        .GROUP_COUNT (GROUP_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (w_entry),
        .i_valid    (w_valid),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_rsp      (o_rsp)
    );
endmodule
`default_nettype wire

/* design/gphm_checker.sv */
// Port-level checks for the group-probed hash map, bound to the top level.
// Depends on gphm_pkg.
`default_nettype none
module gphm_checker
    import gphm_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_req_ready,
    input wire logic        i_rsp_valid,
    input wire logic        i_rsp_ready,
    input wire logic [1:0]  i_rsp_status,
    input wire logic [31:0] i_rsp_index
);
    // Nothing shown straight after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // No request taken straight after reset, when the table clearing starts
    a_rst_busy: assert property (@(posedge i_clk) !i_rst_n |=> !i_req_ready)
        else $error("ready during clearing");

    // Index only carried on a hit
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != ST_FOUND) |-> (i_rsp_index == 32'd0))
        else $error("index on a non-hit response");

    // Stalled response holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_index)))
        else $error("stalled response changed");
endmodule

bind group_probed_hash_map gphm_checker u_gphm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_index  (o_rsp.found_index)
);
`default_nettype wire
